// ===== sv/prbe_pkg.sv =====
// ----------------------------------------------------------------------------
// prbe_pkg: shared types and constants of the pixel-to-RGBA border expander
// Field widths, register indexes, source format codes and the job record
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
package prbe_pkg;

	localparam int BYTE_W = 8;
	localparam int SIDE_W = 13;
	localparam int CALC_W = 16;
	localparam int PHASE_W = 2;
	localparam int INDEX_W = 2;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [BYTE_W-1:0] CHAN_FULL = 8'hFF;
	localparam logic [BYTE_W-1:0] CHAN_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] BORDER_C = 8'hFF;
	localparam logic [BYTE_W-1:0] BORDER_A = 8'h00;
	localparam logic [SIDE_W-1:0] ROW_BORDER_RUN = 13'd2;
	localparam logic [CALC_W-1:0] WIDTH_BORDER_ADD = 16'd3;

	localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [INDEX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

	typedef enum logic [1:0] {
		FMT_MONO = 2'd0,
		FMT_GREY = 2'd1,
		FMT_RGB = 2'd2,
		FMT_RGBA = 2'd3
	} format_t;

	typedef enum logic [1:0] {
		TAIL_NONE = 2'd0,
		TAIL_ROW = 2'd1,
		TAIL_IMAGE = 2'd2
	} tail_t;

	typedef enum logic [1:0] {
		STEP_HEAD = 2'd0,
		STEP_PIXEL = 2'd1,
		STEP_TAIL = 2'd2
	} step_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic [BYTE_W-1:0] alpha;
		logic head;
		tail_t tail;
		logic [SIDE_W-1:0] border_run;
	} job_t;

endpackage

// ===== sv/prbe_if.sv =====
// ----------------------------------------------------------------------------
// prbe_if: stream channels of the border expander
// Source byte channel and RGBA result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface prbe_byte_if;
	logic valid;
	logic ready;
	logic [prbe_pkg::BYTE_W-1:0] source_byte;

	modport source (output valid, output source_byte, input ready);
	modport sink (input valid, input source_byte, output ready);
endinterface

interface prbe_pixel_if;
	logic valid;
	logic ready;
	logic [prbe_pkg::BYTE_W-1:0] red;
	logic [prbe_pkg::BYTE_W-1:0] green;
	logic [prbe_pkg::BYTE_W-1:0] blue;
	logic [prbe_pkg::BYTE_W-1:0] alpha;
	logic [prbe_pkg::SIDE_W-1:0] run_length;
	logic end_of_item;
	logic end_of_image;

	modport source (output valid, output red, output green, output blue, output alpha,
		output run_length, output end_of_item, output end_of_image, input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		input run_length, input end_of_item, input end_of_image, output ready);
endinterface

// ===== sv/prbe_queue.sv =====
// ----------------------------------------------------------------------------
// prbe_queue: job queue between front end and back end
// Small register FIFO; head entry is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module prbe_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  prbe_pkg::job_t   push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output prbe_pkg::job_t   head_data
);

	localparam int PTR_W = $clog2(prbe_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(prbe_pkg::QUEUE_DEPTH + 1);

	prbe_pkg::job_t   store_q [prbe_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(prbe_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head_data = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(prbe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(prbe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/prbe_front.sv =====
// ----------------------------------------------------------------------------
// prbe_front: byte intake and pixel classification
// Holds the registers, gathers source bytes into pixels, tracks the position
// in the image and pushes one job per complete pixel.
// ----------------------------------------------------------------------------
module prbe_front #(
	parameter int MAX_SIDE = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	prbe_byte_if.sink                        src,
	input  logic                             cfg_we,
	input  logic [prbe_pkg::INDEX_W-1:0]     cfg_index,
	input  logic [prbe_pkg::SIDE_W-1:0]      cfg_data,
	output logic                             push,
	output prbe_pkg::job_t                   push_data,
	input  logic                             full
);

	localparam logic [prbe_pkg::CALC_W-1:0] SIDE_LIMIT = prbe_pkg::CALC_W'(MAX_SIDE);
	localparam logic [prbe_pkg::CALC_W-1:0] SIDE_ONE = prbe_pkg::CALC_W'(1);

	logic [prbe_pkg::SIDE_W-1:0]  width_q;
	logic [prbe_pkg::SIDE_W-1:0]  height_q;
	prbe_pkg::format_t            format_q;
	logic [prbe_pkg::SIDE_W-1:0]  col_q;
	logic [prbe_pkg::SIDE_W-1:0]  row_q;
	logic [prbe_pkg::PHASE_W-1:0] phase_q;
	logic [prbe_pkg::BYTE_W-1:0]  held_red_q;
	logic [prbe_pkg::BYTE_W-1:0]  held_green_q;
	logic [prbe_pkg::BYTE_W-1:0]  held_blue_q;

	logic [prbe_pkg::CALC_W-1:0]  width_eff;
	logic [prbe_pkg::CALC_W-1:0]  height_eff;
	logic                         accept;
	logic                         complete;
	logic                         last_col;
	logic                         last_row;

	assign src.ready = !full;
	assign accept = src.valid && !full;
	assign push = accept && complete;

	always_comb begin
		if (width_q == '0) begin
			width_eff = SIDE_ONE;
		end else if (prbe_pkg::CALC_W'(width_q) > SIDE_LIMIT) begin
			width_eff = SIDE_LIMIT;
		end else begin
			width_eff = prbe_pkg::CALC_W'(width_q);
		end
		if (height_q == '0) begin
			height_eff = SIDE_ONE;
		end else if (prbe_pkg::CALC_W'(height_q) > SIDE_LIMIT) begin
			height_eff = SIDE_LIMIT;
		end else begin
			height_eff = prbe_pkg::CALC_W'(height_q);
		end
	end

	assign last_col = (prbe_pkg::CALC_W'(col_q) + SIDE_ONE >= width_eff);
	assign last_row = (prbe_pkg::CALC_W'(row_q) + SIDE_ONE >= height_eff);

	always_comb begin
		push_data.red = prbe_pkg::BORDER_C;
		push_data.green = prbe_pkg::BORDER_C;
		push_data.blue = prbe_pkg::BORDER_C;
		push_data.alpha = src.source_byte;
		complete = 1'b1;
		unique case (format_q)
			prbe_pkg::FMT_MONO: begin
				push_data.alpha = (src.source_byte != prbe_pkg::CHAN_ZERO) ?
					prbe_pkg::CHAN_FULL : prbe_pkg::CHAN_ZERO;
			end
			prbe_pkg::FMT_GREY: begin
				push_data.alpha = src.source_byte;
			end
			prbe_pkg::FMT_RGB: begin
				complete = (phase_q == 2'd2);
				push_data.red = held_red_q;
				push_data.green = held_green_q;
				push_data.blue = src.source_byte;
				push_data.alpha = prbe_pkg::CHAN_FULL;
			end
			prbe_pkg::FMT_RGBA: begin
				complete = (phase_q == 2'd3);
				push_data.red = held_red_q;
				push_data.green = held_green_q;
				push_data.blue = held_blue_q;
				push_data.alpha = src.source_byte;
			end
			default: begin
				complete = 1'b1;
			end
		endcase
		push_data.head = (col_q == '0) && (row_q == '0);
		if (!last_col) begin
			push_data.tail = prbe_pkg::TAIL_NONE;
		end else if (last_row) begin
			push_data.tail = prbe_pkg::TAIL_IMAGE;
		end else begin
			push_data.tail = prbe_pkg::TAIL_ROW;
		end
		push_data.border_run = prbe_pkg::SIDE_W'(width_eff + prbe_pkg::WIDTH_BORDER_ADD);
	end

	// gathered channel bytes
	always_ff @(posedge clk) begin
		if (accept && !complete) begin
			unique case (phase_q)
				2'd0: held_red_q <= src.source_byte;
				2'd1: held_green_q <= src.source_byte;
				default: held_blue_q <= src.source_byte;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= prbe_pkg::SIDE_W'(1);
			height_q <= prbe_pkg::SIDE_W'(1);
			format_q <= prbe_pkg::FMT_MONO;
			col_q <= '0;
			row_q <= '0;
			phase_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				prbe_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data;
					col_q <= '0;
					row_q <= '0;
					phase_q <= '0;
				end
				prbe_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data;
					col_q <= '0;
					row_q <= '0;
					phase_q <= '0;
				end
				prbe_pkg::REG_PIXEL_FORMAT: begin
					format_q <= prbe_pkg::format_t'(cfg_data[1:0]);
					col_q <= '0;
					row_q <= '0;
					phase_q <= '0;
				end
				default: begin
					// unmapped index: drop
				end
			endcase
		end else if (accept) begin
			if (!complete) begin
				phase_q <= phase_q + 1'b1;
			end else begin
				phase_q <= '0;
				if (!last_col) begin
					col_q <= col_q + 1'b1;
				end else begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/prbe_back.sv =====
// ----------------------------------------------------------------------------
// prbe_back: result sequencer
// Expands a job into its pixel, a leading border run if first in the image, a
// trailing run at a row/image end; registered, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module prbe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  prbe_pkg::job_t head_data,
	output logic           pop,
	prbe_pixel_if.source   dst
);

	prbe_pkg::step_t              step_q;
	prbe_pkg::step_t              step_next;
	logic                         out_valid_q;
	logic [prbe_pkg::BYTE_W-1:0]  red_q;
	logic [prbe_pkg::BYTE_W-1:0]  green_q;
	logic [prbe_pkg::BYTE_W-1:0]  blue_q;
	logic [prbe_pkg::BYTE_W-1:0]  alpha_q;
	logic [prbe_pkg::SIDE_W-1:0]  run_q;
	logic                         eoi_item_q;
	logic                         eoi_image_q;

	logic                         advance;
	logic [prbe_pkg::BYTE_W-1:0]  red_d;
	logic [prbe_pkg::BYTE_W-1:0]  green_d;
	logic [prbe_pkg::BYTE_W-1:0]  blue_d;
	logic [prbe_pkg::BYTE_W-1:0]  alpha_d;
	logic [prbe_pkg::SIDE_W-1:0]  run_d;
	logic                         eoi_item_d;
	logic                         eoi_image_d;

	assign advance = !empty && (!out_valid_q || dst.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= prbe_pkg::STEP_HEAD;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_next;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (dst.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		step_next = step_q;
		pop = 1'b0;
		red_d = prbe_pkg::BORDER_C;
		green_d = prbe_pkg::BORDER_C;
		blue_d = prbe_pkg::BORDER_C;
		alpha_d = prbe_pkg::BORDER_A;
		run_d = head_data.border_run;
		eoi_item_d = 1'b0;
		eoi_image_d = 1'b0;
		unique case (step_q)
			prbe_pkg::STEP_HEAD, prbe_pkg::STEP_PIXEL: begin
				if (step_q == prbe_pkg::STEP_HEAD && head_data.head) begin
					if (advance) begin
						step_next = prbe_pkg::STEP_PIXEL;
					end
				end else begin
					red_d = head_data.red;
					green_d = head_data.green;
					blue_d = head_data.blue;
					alpha_d = head_data.alpha;
					run_d = prbe_pkg::SIDE_W'(1);
					eoi_item_d = (head_data.tail == prbe_pkg::TAIL_NONE);
					if (advance) begin
						if (head_data.tail == prbe_pkg::TAIL_NONE) begin
							pop = 1'b1;
							step_next = prbe_pkg::STEP_HEAD;
						end else begin
							step_next = prbe_pkg::STEP_TAIL;
						end
					end
				end
			end
			prbe_pkg::STEP_TAIL: begin
				eoi_item_d = 1'b1;
				if (head_data.tail == prbe_pkg::TAIL_IMAGE) begin
					eoi_image_d = 1'b1;
				end else begin
					run_d = prbe_pkg::ROW_BORDER_RUN;
				end
				if (advance) begin
					pop = 1'b1;
					step_next = prbe_pkg::STEP_HEAD;
				end
			end
			default: begin
				step_next = prbe_pkg::STEP_HEAD;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			red_q <= red_d;
			green_q <= green_d;
			blue_q <= blue_d;
			alpha_q <= alpha_d;
			run_q <= run_d;
			eoi_item_q <= eoi_item_d;
			eoi_image_q <= eoi_image_d;
		end
	end

	assign dst.valid = out_valid_q;
	assign dst.red = red_q;
	assign dst.green = green_q;
	assign dst.blue = blue_q;
	assign dst.alpha = alpha_q;
	assign dst.run_length = run_q;
	assign dst.end_of_item = eoi_item_q;
	assign dst.end_of_image = eoi_image_q;

endmodule

// ===== sv/pixel_to_rgba_border_expander.sv =====
// ----------------------------------------------------------------------------
// pixel_to_rgba_border_expander: source bytes to RGBA8888 with a border
// A source byte is taken every cycle while the four-entry job queue has room;
// each complete pixel becomes one job. The back end sends one result per
// cycle while the output is ready, through its output register: one for a
// pixel, one more at a row or image end, one more before the image's start;
// output throughput is the limit, set by the single-result output register.
// Mono and greyscale give a pixel per byte, RGB per three, RGBA per four.
// Any write to a mapped register index starts a new image.
// ----------------------------------------------------------------------------
module pixel_to_rgba_border_expander #(
	parameter int MAX_SIDE = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	prbe_byte_if.sink                    src,
	prbe_pixel_if.source                 dst,
	input  logic                         cfg_we,
	input  logic [prbe_pkg::INDEX_W-1:0] cfg_index,
	input  logic [prbe_pkg::SIDE_W-1:0]  cfg_data
);

	logic           push;
	prbe_pkg::job_t push_data;
	logic           full;
	logic           pop;
	logic           empty;
	prbe_pkg::job_t head_data;

	prbe_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.src(src),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.push_data(push_data),
		.full(full)
	);

	prbe_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.empty(empty),
		.head_data(head_data)
	);

	prbe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head_data(head_data),
		.pop(pop),
		.dst(dst)
	);

endmodule
